/* sv/lz77d_pkg.sv */
// Shared types and constants for the LZ77 token decoder.
// Used by lz77_token_decoder_core; depends on nothing else.
package lz77d_pkg;

    // Fixed field widths of the token and byte beats.
    localparam int OFF_W  = 12;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;

    // Width of the shift counter used by the offset reduction sequencer.
    localparam int STEP_W = $clog2(OFF_W);

    localparam int DEFAULT_WINDOW_DEPTH = 4096;
    localparam int DEFAULT_MAX_MATCH    = 18;

    // History entries that were never written read as a space.
    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_COPY,
        ST_LIT
    } dec_state_t;

endpackage

/* sv/lz77d_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// A read of the address being written in the same cycle returns the old data.
// No dependencies.
module lz77d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/lz77_token_decoder_core.sv */
// LZ77 token decoder: circular history window in one RAM, copy and literal output.
// Depends on lz77d_pkg and lz77d_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  token    | token_valid/stall    | back_offset[11:0] match_length[4:0] literal_byte[7:0]
//  byte     | byte_valid/stall     | data_byte[7:0] last
//
// A token whose clamped match length is L yields L+1 byte beats: the token is
// accepted, then there is one history RAM read per copied byte and one slot for
// the literal.
// For a window depth below 4096 that is not a power of two, the offset is first reduced
// by a compare-and-subtract sequencer. Reset clears the state, count, pointers and
// valid flags; the history is never swept. A write pointer and a wrapped flag mark
// which entries hold data, and unwritten entries read as spaces.
// A stall on the byte side is absorbed by a one-beat skid; reads pause until it drains.
module lz77_token_decoder_core
    import lz77d_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
    parameter int MAX_MATCH    = DEFAULT_MAX_MATCH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              token_valid,
    output logic              token_stall,
    input  logic [OFF_W-1:0]  back_offset,
    input  logic [LEN_W-1:0]  match_length,
    input  logic [BYTE_W-1:0] literal_byte,
    output logic              byte_valid,
    input  logic              byte_stall,
    output logic [BYTE_W-1:0] data_byte,
    output logic              last
);

    localparam int ADDR_W      = $clog2(WINDOW_DEPTH);
    localparam bit DEPTH_POW2  = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;
    localparam bit OFF_WRAPS   = WINDOW_DEPTH < (1 << OFF_W);
    localparam bit NEED_REDUCE = OFF_WRAPS && !DEPTH_POW2;
    localparam int REM_SHIFT   = NEED_REDUCE ? OFF_W - ADDR_W : 0;
    localparam int OFF_MASK    = (OFF_WRAPS && DEPTH_POW2) ? WINDOW_DEPTH - 1
                                                           : (1 << OFF_W) - 1;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int MATCH_CAP   = (MAX_MATCH > LEN_MAX) ? LEN_MAX : MAX_MATCH;

    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [OFF_W-1:0]  OFF_DIV   = OFF_W'(WINDOW_DEPTH);

    dec_state_t state_reg, state_next;

    logic [OFF_W-1:0]  off_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] lit_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ADDR_W-1:0] ip_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic              wrapped_reg;

    // Read stage: a beat whose history data comes back this cycle.
    logic              pend_valid_reg;
    logic              pend_lit_reg;
    logic              pend_fwd_reg;
    logic              pend_blank_reg;
    logic [BYTE_W-1:0] fwd_byte_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] data_byte_reg;
    logic              last_reg;
    logic              skid_valid_reg;
    logic [BYTE_W-1:0] skid_byte_reg;
    logic              skid_last_reg;

    logic              token_accept;
    logic              out_free;
    logic              can_issue;
    logic              issue_copy;
    logic              issue_lit;
    logic [LEN_W-1:0]  len_sat;
    logic [ADDR_W:0]   rd_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wp_inc;
    logic [ADDR_W-1:0] ip_inc;
    logic [OFF_W-1:0]  div_shift;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] byte_cur;

    assign token_accept = token_valid && !token_stall;
    assign len_sat      = (int'(match_length) > MATCH_CAP) ? LEN_W'(MATCH_CAP) : match_length;

    assign out_free  = !out_valid_reg || !byte_stall;
    // Only start a read when the beat it returns is sure to find room.
    assign can_issue = !skid_valid_reg && !(pend_valid_reg && !out_free);

    assign rd_sum  = {1'b0, ip_reg} + DEPTH_X - (ADDR_W + 1)'(off_reg);
    assign rd_addr = (rd_sum >= DEPTH_X) ? ADDR_W'(rd_sum - DEPTH_X) : ADDR_W'(rd_sum);

    assign wp_inc = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign ip_inc = (ip_reg == LAST_ADDR) ? '0 : ip_reg + 1'b1;

    assign div_shift = OFF_DIV << step_reg;

    always_comb
    begin
        if (pend_lit_reg)
        begin
            byte_cur = lit_reg;
        end
        else if (pend_fwd_reg)
        begin
            byte_cur = fwd_byte_reg;
        end
        else if (pend_blank_reg)
        begin
            byte_cur = FILL_BYTE;
        end
        else
        begin
            byte_cur = ram_rdata;
        end
    end

    lz77d_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (pend_valid_reg),
        .waddr (wp_reg),
        .wdata (byte_cur),
        .re    (issue_copy),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        token_stall = 1'b1;
        issue_copy  = 1'b0;
        issue_lit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                token_stall = 1'b0;
                if (token_valid)
                begin
                    if (NEED_REDUCE)
                    begin
                        state_next = ST_REDUCE;
                    end
                    else if (len_sat == '0)
                    begin
                        state_next = ST_LIT;
                    end
                    else
                    begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = (cnt_reg == '0) ? ST_LIT : ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (can_issue)
                begin
                    issue_copy = 1'b1;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_LIT:
            begin
                if (can_issue)
                begin
                    issue_lit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ip_reg         <= '0;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (token_accept)
            begin
                cnt_reg <= len_sat;
            end
            else if (issue_copy)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (issue_copy || issue_lit)
            begin
                ip_reg <= ip_inc;
            end

            if (pend_valid_reg)
            begin
                wp_reg <= wp_inc;
                if (wp_reg == LAST_ADDR)
                begin
                    wrapped_reg <= 1'b1;
                end
            end

            pend_valid_reg <= issue_copy || issue_lit;

            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= pend_valid_reg;
                end
            end
            else if (pend_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (token_accept)
        begin
            off_reg  <= back_offset & OFF_W'(OFF_MASK);
            lit_reg  <= literal_byte;
            step_reg <= STEP_W'(REM_SHIFT);
        end
        else if (state_reg == ST_REDUCE)
        begin
            // Restoring remainder, one shifted multiple of the depth per cycle.
            if (off_reg >= div_shift)
            begin
                off_reg <= off_reg - div_shift;
            end
            step_reg <= step_reg - 1'b1;
        end

        if (issue_copy || issue_lit)
        begin
            pend_lit_reg <= issue_lit;
            // The byte written this cycle is not yet visible through the RAM port.
            pend_fwd_reg   <= pend_valid_reg && (rd_addr == wp_reg);
            pend_blank_reg <= !wrapped_reg && (rd_addr >= wp_reg);
            fwd_byte_reg   <= byte_cur;
        end

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                data_byte_reg <= skid_byte_reg;
                last_reg      <= skid_last_reg;
            end
            else if (pend_valid_reg)
            begin
                data_byte_reg <= byte_cur;
                last_reg      <= pend_lit_reg;
            end
        end
        else if (pend_valid_reg)
        begin
            skid_byte_reg <= byte_cur;
            skid_last_reg <= pend_lit_reg;
        end
    end

    assign byte_valid = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign last       = last_reg;

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held while the output register is empty");

    a_no_arrival_on_full_skid : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !pend_valid_reg)
        else $error("history read returned while the skid is occupied");

    a_pointer_track : assert property (@(posedge clk) disable iff (!rst_n)
        ip_reg == (pend_valid_reg ? wp_inc : wp_reg))
        else $error("issue pointer out of step with write pointer");

    a_copy_count : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (cnt_reg != '0))
        else $error("copy state entered with no bytes left to copy");

endmodule
